@@ src/npm_pkg.sv @@
// Package for the nearest path point matcher.
// Holds the status and operation codes and the command and status structs
// that join the controller and the datapath. Depends on nothing.
`default_nettype none

package npm_pkg;

  localparam int unsigned STATUS_BITS = 2;

  localparam logic [STATUS_BITS-1:0] STATUS_LOAD  = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_QUERY = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_SHORT = 2'd2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // take the input request into the holding registers
    logic write;      // store one path point, prepare a load result
    logic short_res;  // prepare the result for a path that is too short
    logic gear_rd;    // read the entry under the clamped pointer
    logic back_init;  // latch the run gear, arm the backward walk
    logic back_run;   // walk back toward the run start
    logic fwd_init;   // arm the forward scan
    logic fwd_run;    // scan forward over the run
    logic finish;     // form window and move the pointer
    logic emit;       // load the output register
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_query;
    logic short_path;
    logic back_done;
    logic fwd_done;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ src/npm_controller.sv @@
// Controller state machine of the nearest path point matcher.
// Sequences load, backward walk, forward scan and result hand-off.
// Depends on npm_pkg.
`default_nettype none

module npm_controller
  import npm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DISP = 8'b0000_0010,
    S_GEAR = 8'b0000_0100,
    S_BACK = 8'b0000_1000,
    S_FWDI = 8'b0001_0000,
    S_FWD  = 8'b0010_0000,
    S_WIN  = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } ctl_state_t;

  ctl_state_t state;
  ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (!stat.is_query) begin
          cmd.write  = 1'b1;
          state_next = S_EMIT;
        end else if (stat.short_path) begin
          cmd.short_res = 1'b1;
          state_next    = S_EMIT;
        end else begin
          cmd.gear_rd = 1'b1;
          state_next  = S_GEAR;
        end
      end
      S_GEAR: begin
        cmd.back_init = 1'b1;
        state_next    = S_BACK;
      end
      S_BACK: begin
        cmd.back_run = 1'b1;
        if (stat.back_done) begin
          state_next = S_FWDI;
        end
      end
      S_FWDI: begin
        cmd.fwd_init = 1'b1;
        state_next   = S_FWD;
      end
      S_FWD: begin
        cmd.fwd_run = 1'b1;
        if (stat.fwd_done) begin
          state_next = S_WIN;
        end
      end
      S_WIN: begin
        cmd.finish = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/npm_datapath.sv @@
// Datapath of the nearest path point matcher: path table, search pointer,
// walk counters, distance pipeline, best tracking and output register.
// Depends on npm_pkg.
`default_nettype none

module npm_datapath
  import npm_pkg::*;
#(
  parameter int unsigned PATH_DEPTH   = 4096,
  parameter int unsigned COORD_BITS   = 24,
  parameter int unsigned WINDOW_AHEAD = 20,
  localparam int unsigned IDX_W = $clog2(PATH_DEPTH),
  localparam int unsigned CNT_W = IDX_W + 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ctl_cmd_t                      cmd,
  output dp_stat_t                      stat,
  input  logic                          op,
  input  logic [IDX_W-1:0]              point_slot,
  input  logic signed [COORD_BITS-1:0]  pos_x,
  input  logic signed [COORD_BITS-1:0]  pos_y,
  input  logic                          point_forward,
  input  logic                          cfg_valid,
  input  logic [CNT_W-1:0]              cfg_data,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [STATUS_BITS-1:0]        status,
  output logic [IDX_W-1:0]              nearest_index,
  output logic [IDX_W-1:0]              run_end,
  output logic [IDX_W-1:0]              window_first,
  output logic [IDX_W-1:0]              window_end,
  output logic [IDX_W-1:0]              next_start
);

  localparam int unsigned ENT_W = 2 * COORD_BITS + 1;
  localparam int unsigned DIF_W = COORD_BITS + 1;
  localparam int unsigned SQ_W  = 2 * COORD_BITS + 1;
  localparam int unsigned SUM_W = 2 * COORD_BITS + 2;
  localparam int unsigned WIN_W = IDX_W + $clog2(WINDOW_AHEAD + 1);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(PATH_DEPTH);
  localparam logic [WIN_W-1:0] WINDOW_C = WIN_W'(WINDOW_AHEAD);

  // Holding registers for the request in work.
  logic                         cap_op;
  logic [IDX_W-1:0]             cap_slot;
  logic signed [COORD_BITS-1:0] cap_x;
  logic signed [COORD_BITS-1:0] cap_y;
  logic                         cap_fwd;

  logic [CNT_W-1:0] path_len_cfg;
  logic [IDX_W-1:0] ptr;

  // Path table: gear bit, x, y in one word.
  logic [ENT_W-1:0] mem [PATH_DEPTH];
  logic [ENT_W-1:0] rdata;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;

  logic             run_gear;
  logic [IDX_W-1:0] q_idx;
  logic [IDX_W-1:0] run_start;
  logic [IDX_W-1:0] b_addr;
  logic             b_act;
  logic             b_stop;
  logic [IDX_W-1:0] f_addr;
  logic             f_act;
  logic             f_stop;

  logic                    p1_vld;
  logic [IDX_W-1:0]        p1_idx;
  logic signed [DIF_W-1:0] p1_dx;
  logic signed [DIF_W-1:0] p1_dy;
  logic                    p2_vld;
  logic [IDX_W-1:0]        p2_idx;
  logic [SQ_W-1:0]         p2_sqx;
  logic [SQ_W-1:0]         p2_sqy;
  logic                    p3_vld;
  logic [IDX_W-1:0]        p3_idx;
  logic [SUM_W-1:0]        p3_sum;

  logic             have;
  logic [SUM_W-1:0] best;
  logic [IDX_W-1:0] nearest;
  logic [IDX_W-1:0] run_end_r;

  logic [STATUS_BITS-1:0] res_status;
  logic [IDX_W-1:0]       res_nearest;
  logic [IDX_W-1:0]       res_end;
  logic [IDX_W-1:0]       res_wf;
  logic [IDX_W-1:0]       res_we;

  logic [CNT_W-1:0]          len;
  logic [CNT_W-1:0]          last;
  logic                      short_path;
  logic [IDX_W-1:0]          ptr_clamp;
  logic                      slot_ok;
  logic                      rd_gear;
  logic signed [DIF_W-1:0]   rd_x_ext;
  logic signed [DIF_W-1:0]   rd_y_ext;
  logic signed [DIF_W-1:0]   q_x_ext;
  logic signed [DIF_W-1:0]   q_y_ext;
  logic signed [2*DIF_W-1:0] sq_x_full;
  logic signed [2*DIF_W-1:0] sq_y_full;
  logic [SUM_W-1:0]          sum_d;
  logic [IDX_W-1:0]          win_first;
  logic [WIN_W-1:0]          near_ahead;
  logic [WIN_W-1:0]          end_m1;
  logic [WIN_W-1:0]          win_last;
  logic [IDX_W-1:0]          win_end;
  logic [IDX_W-1:0]          ptr_new;

  always_comb begin
    len        = (path_len_cfg > DEPTH_C) ? DEPTH_C : path_len_cfg;
    last       = len - CNT_W'(1);
    short_path = len < CNT_W'(2);
    ptr_clamp  = (CNT_W'(ptr) > last) ? last[IDX_W-1:0] : ptr;
    slot_ok    = CNT_W'(cap_slot) < DEPTH_C;
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd.gear_rd) begin
      rd_en   = 1'b1;
      rd_addr = ptr_clamp;
    end else if (cmd.back_run && b_act && !b_stop) begin
      rd_en   = 1'b1;
      rd_addr = b_addr;
    end else if (cmd.fwd_run && f_act && !f_stop) begin
      rd_en   = 1'b1;
      rd_addr = f_addr;
    end
  end

  always_comb begin
    rd_gear   = rdata[ENT_W-1];
    rd_x_ext  = DIF_W'($signed(rdata[2*COORD_BITS-1:COORD_BITS]));
    rd_y_ext  = DIF_W'($signed(rdata[COORD_BITS-1:0]));
    q_x_ext   = DIF_W'(cap_x);
    q_y_ext   = DIF_W'(cap_y);
    sq_x_full = p1_dx * p1_dx;
    sq_y_full = p1_dy * p1_dy;
    sum_d     = SUM_W'(p2_sqx) + SUM_W'(p2_sqy);
  end

  // Window and pointer move from the finished scan.
  always_comb begin
    win_first  = (nearest != '0) ? nearest - IDX_W'(1) : '0;
    near_ahead = WIN_W'(nearest) + WINDOW_C;
    end_m1     = WIN_W'(run_end_r) - WIN_W'(1);
    if (run_end_r == '0) begin
      win_last = '0;
    end else if (end_m1 < near_ahead) begin
      win_last = end_m1;
    end else begin
      win_last = near_ahead;
    end
    win_end = (win_last > WIN_W'(win_first)) ? win_last[IDX_W-1:0] : win_first;
    ptr_new = (CNT_W'(run_end_r) == CNT_W'(nearest) + CNT_W'(1)) ? run_end_r : nearest;
  end

  always_comb begin
    stat.is_query   = (cap_op == OP_QUERY);
    stat.short_path = short_path;
    stat.back_done  = b_stop || (!b_act && !rd_vld);
    stat.fwd_done   = (!f_act || f_stop) && !rd_vld && !p1_vld && !p2_vld && !p3_vld;
    stat.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_op   <= op;
      cap_slot <= point_slot;
      cap_x    <= pos_x;
      cap_y    <= pos_y;
      cap_fwd  <= point_forward;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      path_len_cfg <= '0;
    end else if (cfg_valid) begin
      path_len_cfg <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write && slot_ok) begin
      mem[cap_slot] <= {cap_fwd, cap_x, cap_y};
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
    rd_idx <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= rd_en;
    end
  end

  // Backward walk: one read issued per cycle, the returning entry checked
  // against the run gear; the first mismatch ends the walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_act  <= 1'b0;
      b_stop <= 1'b0;
    end else if (cmd.back_init) begin
      b_act  <= (q_idx != '0);
      b_stop <= 1'b0;
    end else if (cmd.back_run) begin
      if (b_act && !b_stop && b_addr == '0) begin
        b_act <= 1'b0;
      end
      if (rd_vld && !b_stop && rd_gear != run_gear) begin
        b_stop <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gear_rd) begin
      q_idx <= ptr_clamp;
    end
    if (cmd.back_init) begin
      run_gear  <= rd_gear;
      run_start <= q_idx;
      b_addr    <= q_idx - IDX_W'(1);
    end else if (cmd.back_run) begin
      if (b_act && !b_stop && b_addr != '0) begin
        b_addr <= b_addr - IDX_W'(1);
      end
      if (rd_vld && !b_stop && rd_gear == run_gear) begin
        run_start <= rd_idx;
      end
    end
  end

  // Forward scan issue and first stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      f_act  <= 1'b0;
      f_stop <= 1'b0;
      p1_vld <= 1'b0;
    end else begin
      p1_vld <= 1'b0;
      if (cmd.fwd_init) begin
        f_act  <= CNT_W'(run_start) < last;
        f_stop <= 1'b0;
      end else if (cmd.fwd_run) begin
        if (f_act && !f_stop) begin
          f_act <= (CNT_W'(f_addr) + CNT_W'(1)) < last;
        end
        if (rd_vld && !f_stop) begin
          if (rd_gear == run_gear) begin
            p1_vld <= 1'b1;
          end else begin
            f_stop <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fwd_init) begin
      f_addr    <= run_start;
      run_end_r <= run_start;
    end else if (cmd.fwd_run) begin
      if (f_act && !f_stop) begin
        f_addr <= f_addr + IDX_W'(1);
      end
      if (rd_vld && !f_stop && rd_gear == run_gear) begin
        run_end_r <= rd_idx + IDX_W'(1);
      end
    end
    p1_idx <= rd_idx;
    p1_dx  <= rd_x_ext - q_x_ext;
    p1_dy  <= rd_y_ext - q_y_ext;
    p2_idx <= p1_idx;
    p2_sqx <= sq_x_full[SQ_W-1:0];
    p2_sqy <= sq_y_full[SQ_W-1:0];
    p3_idx <= p2_idx;
    p3_sum <= sum_d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_vld <= 1'b0;
      p3_vld <= 1'b0;
      have   <= 1'b0;
    end else begin
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
      if (cmd.fwd_init) begin
        have <= 1'b0;
      end else if (p3_vld && (!have || p3_sum < best)) begin
        have <= 1'b1;
      end
    end
  end

  // Earliest index wins a tie, since only a strictly smaller sum replaces.
  always_ff @(posedge clk) begin
    if (cmd.fwd_init) begin
      nearest <= q_idx;
    end else if (p3_vld && (!have || p3_sum < best)) begin
      best    <= p3_sum;
      nearest <= p3_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (cmd.finish) begin
      ptr <= ptr_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write || cmd.short_res) begin
      res_status  <= cmd.write ? STATUS_LOAD : STATUS_SHORT;
      res_nearest <= '0;
      res_end     <= '0;
      res_wf      <= '0;
      res_we      <= '0;
    end else if (cmd.finish) begin
      res_status  <= STATUS_QUERY;
      res_nearest <= nearest;
      res_end     <= run_end_r;
      res_wf      <= win_first;
      res_we      <= win_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status        <= res_status;
      nearest_index <= res_nearest;
      run_end       <= res_end;
      window_first  <= res_wf;
      window_end    <= res_we;
      next_start    <= ptr;
    end
  end

endmodule

`default_nettype wire

@@ src/nearest_path_point_matcher.sv @@
// Top level of the nearest path point matcher.
// Joins npm_controller and npm_datapath; depends on npm_pkg.
//
//   channel   direction  handshake            payload
//   in        request    in_valid / in_ready  op, point_slot, pos_x, pos_y, point_forward
//   out       result     out_valid/out_ready  status, nearest_index, run_end,
//                                             window_first, window_end, next_start
//   cfg       write      cfg_valid/cfg_ready  path_points
//
// A load request passes the holding registers, the result register and the
// output register; the next request can be taken as its result appears.
// A query's work grows with (pointer - run start) + (run length), so with
// the path length: the single read port of the path table serves one entry
// per cycle during the backward walk and the forward scan.
// Reset clears the search pointer, the length register and all control
// state; the path table is not cleared and must be loaded before use.
// One finished result waits in the output register while the next request
// is accepted; that request then holds before hand-off until the output
// register is taken.
`default_nettype none

module nearest_path_point_matcher
  import npm_pkg::*;
#(
  parameter int unsigned PATH_DEPTH   = 4096,
  parameter int unsigned COORD_BITS   = 24,
  parameter int unsigned WINDOW_AHEAD = 20,
  localparam int unsigned IDX_W = $clog2(PATH_DEPTH),
  localparam int unsigned CNT_W = IDX_W + 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         op,
  input  logic [IDX_W-1:0]             point_slot,
  input  logic signed [COORD_BITS-1:0] pos_x,
  input  logic signed [COORD_BITS-1:0] pos_y,
  input  logic                         point_forward,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [STATUS_BITS-1:0]       status,
  output logic [IDX_W-1:0]             nearest_index,
  output logic [IDX_W-1:0]             run_end,
  output logic [IDX_W-1:0]             window_first,
  output logic [IDX_W-1:0]             window_end,
  output logic [IDX_W-1:0]             next_start,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CNT_W-1:0]             path_points
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // The length register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  npm_controller u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  npm_datapath #(
    .PATH_DEPTH   (PATH_DEPTH),
    .COORD_BITS   (COORD_BITS),
    .WINDOW_AHEAD (WINDOW_AHEAD)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .op            (op),
    .point_slot    (point_slot),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .point_forward (point_forward),
    .cfg_valid     (cfg_valid),
    .cfg_data      (path_points),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .status        (status),
    .nearest_index (nearest_index),
    .run_end       (run_end),
    .window_first  (window_first),
    .window_end    (window_end),
    .next_start    (next_start)
  );

  // One request at a time: after acceptance the block is busy.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while the previous one is still in work");

  // The nearest point never lies past the run end.
  a_nearest_in_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_QUERY) |-> nearest_index <= run_end)
    else $error("nearest index beyond run end");

  // The pointer moves to the nearest point or to the run end, and the
  // window is never inverted.
  a_pointer_window: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_QUERY) |->
      ((next_start == nearest_index || next_start == run_end) &&
       window_first <= window_end))
    else $error("pointer move or window bounds inconsistent");

  // Loads and short-path queries carry zero indices.
  a_plain_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STATUS_QUERY) |->
      (nearest_index == '0 && run_end == '0 && window_first == '0 &&
       window_end == '0))
    else $error("non-query result carries search indices");

endmodule

`default_nettype wire

@@ sim/tb_nearest_path_point_matcher.sv @@
// Self-checking testbench for nearest_path_point_matcher: path loads, nearest
// point queries and length register writes, checked against a behavioral
// predictor. Depends on npm_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_nearest_path_point_matcher
  import npm_pkg::*;
;

  localparam int unsigned PATH_DEPTH   = 4096;
  localparam int unsigned COORD_W      = 24;
  localparam int unsigned IDX_W        = 12;
  localparam int unsigned LEN_W        = 13;
  localparam int unsigned WINDOW_AHEAD = 20;

  // Every query here walks at most a few dozen points, and about a hundred
  // requests plus the long hold-off stay far below this limit.
  localparam int unsigned LIMIT_CYCLES  = 200000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned END_CYCLES    = 40;
  localparam int unsigned PHASES        = 6;
  localparam int unsigned PHASE_ITEMS   = 8;
  localparam int unsigned FILL_POINTS   = 24;
  localparam int unsigned RUN_POINTS    = 8;

  // One request as it appears on the input ports.
  typedef struct packed {
    logic               op;
    logic [IDX_W-1:0]   slot;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               fwd;
  } req_t;

  // One result as it appears on the output ports.
  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [IDX_W-1:0]       nearest;
    logic [IDX_W-1:0]       run_end;
    logic [IDX_W-1:0]       win_first;
    logic [IDX_W-1:0]       win_end;
    logic [IDX_W-1:0]       next;
  } match_t;

  typedef enum logic {ROW_REQUEST, ROW_LENGTH} row_kind_t;

  // One row of the directed sequence. Rows with typed set carry their own
  // expected result; the others are checked against the predictor.
  typedef struct packed {
    row_kind_t        kind;
    logic [LEN_W-1:0] length;
    req_t             req;
    logic             typed;
    match_t           want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      in_valid      = 1'b0;
  logic                      in_ready;
  logic                      op            = OP_LOAD;
  logic [IDX_W-1:0]          point_slot    = '0;
  logic signed [COORD_W-1:0] pos_x         = '0;
  logic signed [COORD_W-1:0] pos_y         = '0;
  logic                      point_forward = 1'b0;

  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [STATUS_BITS-1:0] status;
  logic [IDX_W-1:0]       nearest_index;
  logic [IDX_W-1:0]       run_end;
  logic [IDX_W-1:0]       window_first;
  logic [IDX_W-1:0]       window_end;
  logic [IDX_W-1:0]       next_start;

  logic             cfg_valid   = 1'b0;
  logic             cfg_ready;
  logic [LEN_W-1:0] path_points = '0;

  // Predictor state: its own copy of the path table, the search pointer and
  // the length register.
  logic [COORD_W-1:0] path_x    [PATH_DEPTH];
  logic [COORD_W-1:0] path_y    [PATH_DEPTH];
  logic               path_gear [PATH_DEPTH];
  logic [IDX_W-1:0]   seek_ptr = '0;
  logic [LEN_W-1:0]   path_len = '0;

  match_t      expected_matches [$];
  stim_row_t   directed_rows [$];
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;
  bit          quiet        = 1'b0;  // no idling on either side
  bit          hold_pending = 1'b0;  // ask the receiver for one long hold-off

  nearest_path_point_matcher u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .point_slot    (point_slot),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .point_forward (point_forward),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .nearest_index (nearest_index),
    .run_end       (run_end),
    .window_first  (window_first),
    .window_end    (window_end),
    .next_start    (next_start),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .path_points   (path_points)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Works out the result of one accepted request and moves the predictor
  // state along with it, the same way the block does.
  function automatic match_t predict_match(input req_t r);
    match_t          m;
    int unsigned     len, idx, s, i, near, scan_end, win_last, wf;
    logic            g;
    longint          dx, dy, d, best;
    bit              have;
    m = '0;
    if (r.op == OP_LOAD) begin
      path_x[r.slot]    = r.x;
      path_y[r.slot]    = r.y;
      path_gear[r.slot] = r.fwd;
      m.status = STATUS_LOAD;
      m.next   = seek_ptr;
      return m;
    end
    len = (path_len < PATH_DEPTH) ? path_len : PATH_DEPTH;
    if (len < 2) begin
      m.status = STATUS_SHORT;
      m.next   = seek_ptr;
      return m;
    end
    // A pointer left beyond the path by a shorter length counts as the
    // last point.
    idx = (seek_ptr > len - 1) ? len - 1 : seek_ptr;
    g = path_gear[idx];
    // Walk back to the first point of the run, and not one point further.
    s = idx;
    while (s > 0 && path_gear[s - 1] == g) s--;
    // Scan forward over the run, never touching the last path point. Only a
    // strictly smaller distance wins, so ties keep the earliest index.
    near = idx;
    have = 1'b0;
    best = 0;
    for (i = s; (i < len - 1) && (path_gear[i] == g); i++) begin
      dx = longint'($signed(path_x[i])) - longint'($signed(r.x));
      dy = longint'($signed(path_y[i])) - longint'($signed(r.y));
      d  = dx * dx + dy * dy;
      if (!have || d < best) begin
        have = 1'b1;
        best = d;
        near = i;
      end
    end
    scan_end = i;
    seek_ptr = (scan_end == near + 1) ? IDX_W'(scan_end) : IDX_W'(near);
    wf = (near > 0) ? near - 1 : 0;
    win_last = near + WINDOW_AHEAD;
    if (scan_end >= 1 && scan_end - 1 < win_last) win_last = scan_end - 1;
    if (scan_end == 0) win_last = 0;
    m.status    = STATUS_QUERY;
    m.nearest   = IDX_W'(near);
    m.run_end   = IDX_W'(scan_end);
    m.win_first = IDX_W'(wf);
    m.win_end   = IDX_W'((win_last > wf) ? win_last : wf);
    m.next      = seek_ptr;
    return m;
  endfunction

  function automatic stim_row_t request_row(input logic o, input int s, input int x,
                                            input int y, input logic f);
    stim_row_t row;
    row = '0;
    row.kind = ROW_REQUEST;
    row.req  = '{op: o, slot: IDX_W'(s), x: COORD_W'(x), y: COORD_W'(y), fwd: f};
    return row;
  endfunction

  // Results that need no working out: loads, short paths.
  function automatic stim_row_t typed_row(input stim_row_t row,
                                          input logic [STATUS_BITS-1:0] st,
                                          input int unsigned nxt);
    row.typed       = 1'b1;
    row.want        = '0;
    row.want.status = st;
    row.want.next   = IDX_W'(nxt);
    return row;
  endfunction

  function automatic stim_row_t length_row(input int unsigned n);
    stim_row_t row;
    row = '0;
    row.kind   = ROW_LENGTH;
    row.length = LEN_W'(n);
    return row;
  endfunction

  // Appends one row to the directed sequence.
  function automatic void add_row(input stim_row_t row);
    directed_rows = {directed_rows, row};
  endfunction

  // Mostly well-formed traffic: queries close to a point of the path and
  // loads that nudge a point or flip its gear, which splits and joins runs.
  // The rest is full-range queries and loads anywhere in the table.
  function automatic req_t random_request(input int unsigned len);
    req_t        r;
    int unsigned pick, k;
    pick = $urandom_range(0, 99);
    k    = $urandom_range(0, len - 1);
    r.op   = OP_QUERY;
    r.slot = IDX_W'($urandom);
    r.x    = COORD_W'($urandom);
    r.y    = COORD_W'($urandom);
    r.fwd  = 1'($urandom);
    if (pick < 60) begin
      r.x = path_x[k] + COORD_W'($urandom_range(0, 400)) - COORD_W'(200);
      r.y = path_y[k] + COORD_W'($urandom_range(0, 400)) - COORD_W'(200);
    end else if (pick >= 70 && pick < 90) begin
      r.op   = OP_LOAD;
      r.slot = IDX_W'(k);
      r.x    = path_x[k] + COORD_W'($urandom_range(0, 400)) - COORD_W'(200);
      r.y    = path_y[k] + COORD_W'($urandom_range(0, 400)) - COORD_W'(200);
      r.fwd  = ($urandom_range(0, 3) == 0) ? !path_gear[k] : path_gear[k];
    end else if (pick >= 90) begin
      r.op = OP_LOAD;
    end
    return r;
  endfunction

  // Offers one request and waits for it to be taken. Valid stays high from
  // one request to the next unless a gap is inserted, so it is never lowered
  // and raised in the same time step.
  task automatic send_request(input req_t r, input logic typed, input match_t want);
    match_t m;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    op            <= r.op;
    point_slot    <= r.slot;
    pos_x         <= r.x;
    pos_y         <= r.y;
    point_forward <= r.fwd;
    do @(posedge clk); while (!in_ready);
    m = predict_match(r);
    expected_matches = {expected_matches, (typed ? want : m)};
  endtask

  // Stops offering requests and waits until every expected result is back.
  task automatic settle_all();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_matches.size() != 0);
  endtask

  // The length register is only written while the block is idle.
  task automatic set_path_length(input int unsigned n);
    settle_all();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid   <= 1'b1;
    path_points <= LEN_W'(n);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    path_len  = LEN_W'(n);
  endtask

  // Queries near one of the first points of the loaded path under a long
  // length. The pointer stays in the first gear run, which ends well inside
  // the loaded part, so no empty slot is ever read.
  task automatic query_long_path();
    req_t        r;
    int unsigned k;
    k = $urandom_range(0, RUN_POINTS - 3);
    r = '0;
    r.op = OP_QUERY;
    r.x  = path_x[k] + COORD_W'($urandom_range(0, 40)) - COORD_W'(20);
    r.y  = path_y[k] + COORD_W'($urandom_range(0, 40)) - COORD_W'(20);
    send_request(r, 1'b0, '0);
  endtask

  // Receiver side: short random stalls, one long hold-off on request, and
  // none at all once the run goes quiet.
  initial begin : result_ready
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Each result taken from the block is compared with the oldest expectation.
  always @(posedge clk) begin : result_check
    match_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_matches.size() == 0) begin
        $error("result with nothing expected: status %0d, nearest_index %0d",
               status, nearest_index);
        mismatches++;
      end else begin
        want = expected_matches.pop_front();
        check_field("status", 16'(want.status), 16'(status));
        check_field("nearest_index", 16'(want.nearest), 16'(nearest_index));
        check_field("run_end", 16'(want.run_end), 16'(run_end));
        check_field("window_first", 16'(want.win_first), 16'(window_first));
        check_field("window_end", 16'(want.win_end), 16'(window_end));
        check_field("next_start", 16'(want.next), 16'(next_start));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    req_t        r;
    stim_row_t   row;
    int unsigned lens [PHASES];
    logic        gear;

    // Directed part. The short path is set up with gears 1 1 1 0 0 0 1 on
    // slots 0 to 6, slot 0 at one corner of the coordinate range and the
    // others along the x axis, 100 apart.
    add_row(typed_row(request_row(OP_QUERY, 0, 0, 0, 0), STATUS_SHORT, 0));
    add_row(typed_row(request_row(OP_LOAD, 0, 8388607, -8388608, 1), STATUS_LOAD, 0));
    add_row(typed_row(request_row(OP_LOAD, 4095, -8388608, 8388607, 0), STATUS_LOAD, 0));
    add_row(length_row(0));
    add_row(typed_row(request_row(OP_QUERY, 0, -8388608, 8388607, 1), STATUS_SHORT, 0));
    add_row(length_row(1));
    add_row(typed_row(request_row(OP_QUERY, 0, 0, 0, 0), STATUS_SHORT, 0));
    add_row(typed_row(request_row(OP_LOAD, 1, 0, 0, 1), STATUS_LOAD, 0));
    add_row(typed_row(request_row(OP_LOAD, 2, 100, 0, 1), STATUS_LOAD, 0));
    add_row(typed_row(request_row(OP_LOAD, 3, 200, 0, 0), STATUS_LOAD, 0));
    add_row(typed_row(request_row(OP_LOAD, 4, 300, 0, 0), STATUS_LOAD, 0));
    add_row(typed_row(request_row(OP_LOAD, 5, 400, 0, 0), STATUS_LOAD, 0));
    add_row(typed_row(request_row(OP_LOAD, 6, 500, 0, 1), STATUS_LOAD, 0));
    // Two points: a one-point scan, so the pointer steps to the run end.
    add_row(length_row(2));
    add_row(request_row(OP_QUERY, 0, 0, 0, 0));
    add_row(length_row(7));
    // Nearest is the last point of the forward run.
    add_row(request_row(OP_QUERY, 0, 150, 0, 0));
    // Equal distance to slots 4 and 5: the earlier one wins.
    add_row(request_row(OP_QUERY, 0, 350, 0, 0));
    // Backward walk from slot 4 ends exactly at the run start, slot 3.
    add_row(request_row(OP_QUERY, 0, 0, 0, 0));
    // Nearest just before the last path point moves the pointer onto it.
    add_row(request_row(OP_QUERY, 0, 400, 0, 0));
    // The run starts at the last path point, so nothing is scanned.
    add_row(request_row(OP_QUERY, 0, 0, 0, 0));
    // Shorter path leaves the pointer beyond its end.
    add_row(length_row(6));
    add_row(request_row(OP_QUERY, 0, 300, 0, 0));
    add_row(length_row(2));
    add_row(request_row(OP_QUERY, 0, 0, 0, 0));
    // Back in the first run: queries at both corners of the range give the
    // largest distances.
    add_row(length_row(7));
    add_row(request_row(OP_QUERY, 0, 8388607, -8388608, 0));
    add_row(request_row(OP_QUERY, 0, -8388608, 8388607, 0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[n]) begin
      row = directed_rows[n];
      if (row.kind == ROW_LENGTH) begin
        set_path_length(row.length);
      end else begin
        send_request(row.req, row.typed, row.want);
      end
    end

    // Load the start of a path in three gear runs of equal length. The
    // pointer sits in the first run here, and every later short path stays
    // inside the loaded points.
    gear = 1'b1;
    for (int i = 0; i < FILL_POINTS; i++) begin
      if (i != 0 && (i % RUN_POINTS) == 0) gear = !gear;
      r = '0;
      r.op   = OP_LOAD;
      r.slot = IDX_W'(i);
      r.x    = COORD_W'(i * 64) - COORD_W'(131072) + COORD_W'($urandom_range(0, 31));
      r.y    = COORD_W'((i % 700) * 40) + COORD_W'($urandom_range(0, 31));
      r.fwd  = gear;
      send_request(r, 1'b0, '0);
    end
    // Full table length, then a length beyond the table that clamps to it.
    set_path_length(PATH_DEPTH);
    repeat (3) query_long_path();
    set_path_length((1 << LEN_W) - 1);
    repeat (2) query_long_path();

    // Random phases over short paths.
    lens = '{3, $urandom_range(4, FILL_POINTS), 2, $urandom_range(12, FILL_POINTS),
             $urandom_range(4, FILL_POINTS), $urandom_range(8, FILL_POINTS)};
    for (int p = 0; p < PHASES; p++) begin
      set_path_length(lens[p]);
      // One long hold on the result side while requests keep coming, so the
      // output register fills and the input stalls.
      if (p == 1) hold_pending = 1'b1;
      if (p == PHASES - 1) quiet = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == PHASE_ITEMS / 2) settle_all();
        send_request(random_request(lens[p]), 1'b0, '0);
      end
    end

    settle_all();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
